FILE: sv/wfr_pkg.sv
package wfr_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WORD_W     = 64;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_WIDTH     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_WIDTH     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPACING   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPACING   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_IGNORE_PARITY = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_LIMIT    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_PRESENT_MIN   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_VALID_MIN     = 3'd7;

  localparam logic [15:0]      RST_MIN_WIDTH   = 16'd20;
  localparam logic [15:0]      RST_MAX_WIDTH   = 16'd200;
  localparam logic [19:0]      RST_MIN_SPACING = 20'd200;
  localparam logic [19:0]      RST_MAX_SPACING = 20'd20000;
  localparam logic             RST_IGNORE_PAR  = 1'b0;
  localparam logic [23:0]      RST_IDLE_LIMIT  = 24'd500000;
  localparam logic [CNT_W-1:0] RST_PRESENT_MIN = 7'd30;
  localparam logic [CNT_W-1:0] RST_VALID_MIN   = 7'd26;

  typedef struct packed {
    logic [15:0]      min_width_us;
    logic [15:0]      max_width_us;
    logic [19:0]      min_spacing_us;
    logic [19:0]      max_spacing_us;
    logic             ignore_parity;
    logic [23:0]      idle_limit_us;
    logic [CNT_W-1:0] present_min_bits;
    logic [CNT_W-1:0] valid_min_bits;
  } wfr_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] frame_bits;
    logic [CNT_W-1:0]  bit_count;
    logic              spacing_error;
    logic              width_error;
    logic              parity_error;
    logic              frame_valid;
    logic [6:0]        site_code;
    logic [23:0]       card_number;
    logic              card_ok;
    logic              card_present;
  } wfr_result_t;

endpackage

FILE: sv/wfr_frame_core.sv
module wfr_frame_core #(
  parameter int unsigned MAX_FRAME_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_accept,
  input  logic                 command,
  input  logic                 line,
  input  logic                 falling,
  input  logic [31:0]          time_us,
  input  wfr_pkg::wfr_cfg_t    cfg,
  output wfr_pkg::wfr_result_t result
);
  import wfr_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BITS);

  logic [MAX_FRAME_BITS-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      await_r, await_nxt;
  logic                      await_line_r, await_line_nxt;
  logic [TIME_W-1:0]         last_fall_r, last_fall_nxt;
  logic [TIME_W-1:0]         last_rise_r, last_rise_nxt;
  logic                      wbad_r, wbad_nxt;
  logic                      sbad_r, sbad_nxt;

  logic [TIME_W-1:0] idle;
  logic [TIME_W-1:0] pulse_width;
  logic [TIME_W-1:0] gap;
  logic [WORD_W-1:0] word;
  logic              present;
  logic              par_bad;
  logic              ok;

  assign idle        = time_us - last_fall_r;
  assign pulse_width = time_us - last_fall_r;
  assign gap         = last_fall_r - last_rise_r;
  assign word        = WORD_W'(shift_r);
  assign present     = (idle > {8'd0, cfg.idle_limit_us}) && (cnt_r > cfg.present_min_bits);
  // bit 32 must match the xor of the site bits, bit 0 the xor of the card number bits
  assign par_bad = !cfg.ignore_parity &&
                   (((^word[31:25]) != word[32]) || ((^word[24:1]) != word[0]));
  assign ok      = !par_bad && !wbad_r && !sbad_r;

  always_comb begin
    result              = '0;
    result.card_present = present;
    if (command) begin
      result.card_ok       = ok;
      result.card_number   = word[24:1];
      result.site_code     = word[31:25];
      result.frame_valid   = ok && (cnt_r >= cfg.valid_min_bits);
      result.parity_error  = par_bad;
      result.width_error   = wbad_r;
      result.spacing_error = sbad_r;
      result.bit_count     = cnt_r;
      result.frame_bits    = word;
    end
  end

  always_comb begin
    shift_nxt      = shift_r;
    cnt_nxt        = cnt_r;
    await_nxt      = await_r;
    await_line_nxt = await_line_r;
    last_fall_nxt  = last_fall_r;
    last_rise_nxt  = last_rise_r;
    wbad_nxt       = wbad_r;
    sbad_nxt       = sbad_r;
    if (item_accept) begin
      if (command) begin
        shift_nxt     = '0;
        cnt_nxt       = '0;
        await_nxt     = 1'b0;
        last_fall_nxt = '0;
        wbad_nxt      = 1'b0;
        sbad_nxt      = 1'b0;
      end else if (falling) begin
        if (cnt_r == '0) begin
          wbad_nxt = 1'b0;
          sbad_nxt = 1'b0;
        end
        shift_nxt      = {shift_r[MAX_FRAME_BITS-2:0], line};
        await_line_nxt = line;
        await_nxt      = 1'b1;
        last_fall_nxt  = time_us;
      end else if (await_r && (line == await_line_r)) begin
        await_nxt = 1'b0;
        // once the frame is full, further bits are still shifted in but neither counted nor checked
        if (cnt_r < MAX_CNT) begin
          if ((pulse_width < {16'd0, cfg.min_width_us}) ||
              (pulse_width > {16'd0, cfg.max_width_us})) begin
            wbad_nxt = 1'b1;
          end
          if ((cnt_r != '0) &&
              ((gap < {12'd0, cfg.min_spacing_us}) || (gap > {12'd0, cfg.max_spacing_us}))) begin
            sbad_nxt = 1'b1;
          end
          last_rise_nxt = time_us;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r      <= '0;
      cnt_r        <= '0;
      await_r      <= 1'b0;
      await_line_r <= 1'b0;
      last_fall_r  <= '0;
      last_rise_r  <= '0;
      wbad_r       <= 1'b0;
      sbad_r       <= 1'b0;
    end else begin
      shift_r      <= shift_nxt;
      cnt_r        <= cnt_nxt;
      await_r      <= await_nxt;
      await_line_r <= await_line_nxt;
      last_fall_r  <= last_fall_nxt;
      last_rise_r  <= last_rise_nxt;
      wbad_r       <= wbad_nxt;
      sbad_r       <= sbad_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("bit count beyond frame size");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_accept && command |=> (cnt_r == '0) && !await_r && !wbad_r && !sbad_r)
    else $error("read did not clear the frame");

  a_fall_arms: assert property (@(posedge clk) disable iff (!rst_n)
    item_accept && !command && falling |=> await_r && (await_line_r == $past(line)))
    else $error("fall did not arm the rise wait");

  a_stray_rise: assert property (@(posedge clk) disable iff (!rst_n)
    item_accept && !command && !falling && !await_r |=> $stable(cnt_r) && $stable(last_rise_r))
    else $error("unmatched rise changed the frame");
`endif

endmodule

FILE: sv/wiegand_frame_receiver.sv
// Wiegand frame receiver. Each input beat is either a timestamped edge on the data0/data1
// lines (in_tuser = 0) or a read of the frame (in_tuser = 1), and every input beat gives
// exactly one output beat. A fall shifts a bit into the frame, the matching rise counts it
// and checks pulse width and rise-to-fall spacing; a read reports site, card number,
// parity and timing status and clears the frame. Timestamps are 32-bit microseconds and
// may wrap. The block takes one beat per clock and registers each result: the result
// register is the only stage, and in_tready falls only while that register holds a beat
// that out_tready has not yet taken. Configuration writes are taken in any cycle but
// belong in idle periods.
module wiegand_frame_receiver #(
  parameter int unsigned MAX_FRAME_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [39:0]                       in_tdata,   // line, falling, time_us[31:0], pad
  input  logic                              in_tuser,   // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // card_present, card_ok, card_number[23:0], site_code[6:0], frame_valid,
  // parity_error, width_error, spacing_error, bit_count[6:0], frame_bits[63:0], pad
  output logic [111:0]                      out_tdata,
  input  logic                              cfg_we,
  input  logic [wfr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [wfr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import wfr_pkg::*;

  wfr_cfg_t    cfg_r, cfg_nxt;
  wfr_result_t result;
  wfr_result_t out_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic        in_accept;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_MIN_WIDTH:     cfg_nxt.min_width_us     = cfg_wdata[15:0];
        REG_MAX_WIDTH:     cfg_nxt.max_width_us     = cfg_wdata[15:0];
        REG_MIN_SPACING:   cfg_nxt.min_spacing_us   = cfg_wdata[19:0];
        REG_MAX_SPACING:   cfg_nxt.max_spacing_us   = cfg_wdata[19:0];
        REG_IGNORE_PARITY: cfg_nxt.ignore_parity    = cfg_wdata[0];
        REG_IDLE_LIMIT:    cfg_nxt.idle_limit_us    = cfg_wdata[23:0];
        REG_PRESENT_MIN:   cfg_nxt.present_min_bits = cfg_wdata[CNT_W-1:0];
        REG_VALID_MIN:     cfg_nxt.valid_min_bits   = cfg_wdata[CNT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_width_us     <= RST_MIN_WIDTH;
      cfg_r.max_width_us     <= RST_MAX_WIDTH;
      cfg_r.min_spacing_us   <= RST_MIN_SPACING;
      cfg_r.max_spacing_us   <= RST_MAX_SPACING;
      cfg_r.ignore_parity    <= RST_IGNORE_PAR;
      cfg_r.idle_limit_us    <= RST_IDLE_LIMIT;
      cfg_r.present_min_bits <= RST_PRESENT_MIN;
      cfg_r.valid_min_bits   <= RST_VALID_MIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wfr_frame_core #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (in_accept),
    .command     (in_tuser),
    .line        (in_tdata[0]),
    .falling     (in_tdata[1]),
    .time_us     (in_tdata[33:2]),
    .cfg         (cfg_r),
    .result      (result)
  );

  assign out_valid_nxt = in_accept || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0,
                       out_data_r.frame_bits,
                       out_data_r.bit_count,
                       out_data_r.spacing_error,
                       out_data_r.width_error,
                       out_data_r.parity_error,
                       out_data_r.frame_valid,
                       out_data_r.site_code,
                       out_data_r.card_number,
                       out_data_r.card_ok,
                       out_data_r.card_present};

endmodule
